// ===== rtl/core/rsom_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated shape occluder mask package
// Shared widths, register indexes, shape codes, reset values and pipe word types.
// ----------------------------------------------------------------------------
package rsom_pkg;

    // Default parameter values for the top level.
    localparam int COORD_BITS_DEF     = 12;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // Fixed field widths.
    localparam int COLOR_BITS     = 8;
    localparam int SHAPE_BITS     = 3;
    localparam int CENTER_BITS    = 14;
    localparam int TRIG_BITS      = 16;
    localparam int SIZE_BITS      = 12;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE_KIND   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OCCLUDER_X   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OCCLUDER_Y   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COS_ROTATION = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIN_ROTATION = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_A       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_B       = 3'd6;

    // Shape codes; the unused codes mean no shape.
    localparam logic [SHAPE_BITS-1:0] SHAPE_NONE    = 3'd0;
    localparam logic [SHAPE_BITS-1:0] SHAPE_WIRE    = 3'd1;
    localparam logic [SHAPE_BITS-1:0] SHAPE_CIRCLE  = 3'd2;
    localparam logic [SHAPE_BITS-1:0] SHAPE_ELLIPSE = 3'd3;
    localparam logic [SHAPE_BITS-1:0] SHAPE_SQUARE  = 3'd4;

    // Register reset values.
    localparam logic signed [TRIG_BITS-1:0] COS_RESET  = 16'sd32767;
    localparam logic signed [TRIG_BITS-1:0] SIN_RESET  = 16'sd0;
    localparam logic [SIZE_BITS-1:0]        SIZE_RESET = 12'd1;

    // Pixel word fields that travel down the pipe; stage 7 clears them for a blocked pixel.
    typedef struct packed {
        logic                  mask;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } pass_t;

    // Shape test results gathered along the pipe.
    typedef struct packed {
        logic wire_ok;
        logic sq_ok;
        logic circ_ok;
    } flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/rotated_shape_occluder_mask_core.sv =====
// Each input word passes through seven register stages, s1 to s7, to the output word.
// Throughput: one word per cycle through a seven-stage pipeline unless out_ready stalls it; the
// ellipse test splits its wide squares into half-width partial products over two stages.
// Writes load the config registers; size products re-register from them (abab via ab).
// Reset (rst_n low, asynchronous) empties the pipe and restores register defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// Rotated shape occluder mask core
// Rotates each pixel's offset from the occluder center and blacks out masked
// pixels that fall inside the selected wire, circle, ellipse or square.
// ----------------------------------------------------------------------------
module rotated_shape_occluder_mask_core #(
    parameter int COORD_BITS     = rsom_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = rsom_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rsom_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [rsom_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Input pixel channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [COORD_BITS-1:0]                pixel_col,
    input  wire logic [COORD_BITS-1:0]                pixel_row,
    input  wire logic                                 in_mask,
    input  wire logic [rsom_pkg::COLOR_BITS-1:0]      red_in,
    input  wire logic [rsom_pkg::COLOR_BITS-1:0]      green_in,
    input  wire logic [rsom_pkg::COLOR_BITS-1:0]      blue_in,
    // Output pixel channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [rsom_pkg::COLOR_BITS-1:0]           red_out,
    output logic [rsom_pkg::COLOR_BITS-1:0]           green_out,
    output logic [rsom_pkg::COLOR_BITS-1:0]           blue_out,
    output logic                                      mask_out,
    output logic                                      was_blocked
);

    import rsom_pkg::*;

    // Offset width: column minus a 14-bit signed center.
    localparam int DX_W   = ((COORD_BITS > CENTER_BITS - 1) ? COORD_BITS : CENTER_BITS - 1) + 2;
    // Single rotation product, rotated sum, and its magnitude.
    localparam int PR_W   = DX_W + TRIG_BITS;
    localparam int ROT_W  = PR_W + 1;
    localparam int R_W    = DX_W + TRIG_BITS - 1;
    // Wire and square compare width: 2|R| against A*K.
    localparam int AK_W   = SIZE_BITS + TRIG_FRAC_BITS;
    localparam int WC_W   = (R_W + 1 > AK_W) ? R_W + 1 : AK_W;
    // Circle: R^2 + S^2 against A^2 * K^2.
    localparam int SQ_W   = 2 * R_W;
    localparam int AA_W   = 2 * SIZE_BITS;
    localparam int C_W    = (SQ_W + 1 > AA_W + 2 * TRIG_FRAC_BITS) ?
                            SQ_W + 1 : AA_W + 2 * TRIG_FRAC_BITS;
    // Ellipse: (R*B)^2 + (S*A)^2 against (A*B)^2 * K^2.
    localparam int P_W    = R_W + SIZE_BITS;
    localparam int PL_W   = P_W / 2;
    localparam int PH_W   = P_W - PL_W;
    localparam int PHH_W  = 2 * PH_W;
    localparam int PHL_W  = PH_W + PL_W;
    localparam int PLL_W  = 2 * PL_W;
    localparam int PSQ_W  = 2 * P_W;
    localparam int ABAB_W = 2 * AA_W;
    localparam int E_W    = (PSQ_W + 1 > ABAB_W + 2 * TRIG_FRAC_BITS) ?
                            PSQ_W + 1 : ABAB_W + 2 * TRIG_FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SHAPE_BITS-1:0]         shape_kind_reg;
    logic signed [CENTER_BITS-1:0] occluder_x_reg;
    logic signed [CENTER_BITS-1:0] occluder_y_reg;
    logic signed [TRIG_BITS-1:0]   cos_reg;
    logic signed [TRIG_BITS-1:0]   sin_reg;
    logic [SIZE_BITS-1:0]          size_a_reg;
    logic [SIZE_BITS-1:0]          size_b_reg;
    logic [AA_W-1:0]               aa_reg;
    logic [AA_W-1:0]               ab_reg;
    logic [ABAB_W-1:0]             abab_reg;

    assign cfg_ready = 1'b1;

    // Register writes; every index is always taken, unknown ones are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg <= SHAPE_NONE;
            occluder_x_reg <= '0;
            occluder_y_reg <= '0;
            cos_reg        <= COS_RESET;
            sin_reg        <= SIN_RESET;
            size_a_reg     <= SIZE_RESET;
            size_b_reg     <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHAPE_KIND:   shape_kind_reg <= cfg_data[SHAPE_BITS-1:0];
                REG_OCCLUDER_X:   occluder_x_reg <= cfg_data[CENTER_BITS-1:0];
                REG_OCCLUDER_Y:   occluder_y_reg <= cfg_data[CENTER_BITS-1:0];
                REG_COS_ROTATION: cos_reg        <= cfg_data[TRIG_BITS-1:0];
                REG_SIN_ROTATION: sin_reg        <= cfg_data[TRIG_BITS-1:0];
                REG_SIZE_A:       size_a_reg     <= cfg_data[SIZE_BITS-1:0];
                REG_SIZE_B:       size_b_reg     <= cfg_data[SIZE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Size products used as shape limits; they only follow the registers.
    always_ff @(posedge clk)
    begin
        aa_reg   <= AA_W'(size_a_reg) * AA_W'(size_a_reg);
        ab_reg   <= AA_W'(size_a_reg) * AA_W'(size_b_reg);
        abab_reg <= ABAB_W'(ab_reg) * ABAB_W'(ab_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or drains.
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic en1, en2, en3, en4, en5, en6, en7;

    assign en7      = !s7_v_reg || out_ready;
    assign en6      = !s6_v_reg || en7;
    assign en5      = !s5_v_reg || en6;
    assign en4      = !s4_v_reg || en5;
    assign en3      = !s3_v_reg || en4;
    assign en2      = !s2_v_reg || en3;
    assign en1      = !s1_v_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_v_reg <= in_valid;
            if (en2) s2_v_reg <= s1_v_reg;
            if (en3) s3_v_reg <= s2_v_reg;
            if (en4) s4_v_reg <= s3_v_reg;
            if (en5) s5_v_reg <= s4_v_reg;
            if (en6) s6_v_reg <= s5_v_reg;
            if (en7) s7_v_reg <= s6_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    pass_t                    s1_pass_reg, s2_pass_reg, s3_pass_reg, s4_pass_reg;
    pass_t                    s5_pass_reg, s6_pass_reg, s7_pass_reg;
    logic signed [DX_W-1:0]   s1_dx_reg, s1_dy_reg;
    logic signed [PR_W-1:0]   s2_cdx_reg, s2_sdy_reg, s2_cdy_reg, s2_sdx_reg;
    logic [R_W-1:0]           s3_ur_reg, s3_us_reg;
    logic [SQ_W-1:0]          s4_ur2_reg, s4_us2_reg;
    logic [P_W-1:0]           s4_p_reg, s4_q_reg;
    flags_t                   s4_flags_reg, s5_flags_reg, s6_flags_reg;
    logic [PHH_W-1:0]         s5_phh_reg, s5_qhh_reg;
    logic [PHL_W-1:0]         s5_phl_reg, s5_qhl_reg;
    logic [PLL_W-1:0]         s5_pll_reg, s5_qll_reg;
    logic [PSQ_W-1:0]         s6_p2_reg, s6_q2_reg;
    logic                     s7_blocked_reg;

    // Next values
    pass_t                    s1_pass_next;
    logic signed [DX_W-1:0]   s1_dx_next, s1_dy_next;
    logic signed [PR_W-1:0]   s2_cdx_next, s2_sdy_next, s2_cdy_next, s2_sdx_next;
    logic signed [ROT_W-1:0]  rx, ry;
    logic [ROT_W-1:0]         rx_abs, ry_abs;
    logic [R_W-1:0]           s3_ur_next, s3_us_next;
    logic [WC_W-1:0]          ak_wide;
    logic [SQ_W-1:0]          s4_ur2_next, s4_us2_next;
    logic [P_W-1:0]           s4_p_next, s4_q_next;
    flags_t                   s4_flags_next, s5_flags_next;
    logic [C_W-1:0]           circ_sum, circ_lim;
    logic [PH_W-1:0]          p_hi, q_hi;
    logic [PL_W-1:0]          p_lo, q_lo;
    logic [PHH_W-1:0]         s5_phh_next, s5_qhh_next;
    logic [PHL_W-1:0]         s5_phl_next, s5_qhl_next;
    logic [PLL_W-1:0]         s5_pll_next, s5_qll_next;
    logic [PSQ_W-1:0]         s6_p2_next, s6_q2_next;
    logic [E_W-1:0]           ell_sum, ell_lim;
    logic                     ell_ok;
    logic                     shape_hit;
    logic                     s7_blocked_next;
    pass_t                    s7_pass_next;

    // Stage 1: offset from the occluder center.
    always_comb
    begin
        s1_pass_next = '{mask: in_mask, red: red_in, green: green_in, blue: blue_in};
        s1_dx_next   = $signed({{(DX_W - COORD_BITS){1'b0}}, pixel_col})
                       - DX_W'(occluder_x_reg);
        s1_dy_next   = $signed({{(DX_W - COORD_BITS){1'b0}}, pixel_row})
                       - DX_W'(occluder_y_reg);
    end

    // Stage 2: the four rotation products.
    always_comb
    begin
        s2_cdx_next = PR_W'(cos_reg) * PR_W'(s1_dx_reg);
        s2_sdy_next = PR_W'(sin_reg) * PR_W'(s1_dy_reg);
        s2_cdy_next = PR_W'(cos_reg) * PR_W'(s1_dy_reg);
        s2_sdx_next = PR_W'(sin_reg) * PR_W'(s1_dx_reg);
    end

    // Stage 3: rotated coordinates and their magnitudes.
    always_comb
    begin
        rx         = ROT_W'(s2_cdx_reg) + ROT_W'(s2_sdy_reg);
        ry         = ROT_W'(s2_cdy_reg) - ROT_W'(s2_sdx_reg);
        rx_abs     = rx[ROT_W-1] ? -rx : rx;
        ry_abs     = ry[ROT_W-1] ? -ry : ry;
        s3_ur_next = rx_abs[R_W-1:0];
        s3_us_next = ry_abs[R_W-1:0];
    end

    // Stage 4: band tests, circle squares and ellipse scaling.
    always_comb
    begin
        ak_wide               = WC_W'(size_a_reg) << TRIG_FRAC_BITS;
        s4_flags_next.wire_ok = (WC_W'(s3_ur_reg) << 1) <= ak_wide;
        s4_flags_next.sq_ok   = (WC_W'(s3_us_reg) << 1) <= ak_wide;
        s4_flags_next.circ_ok = 1'b0;
        s4_ur2_next           = SQ_W'(s3_ur_reg) * SQ_W'(s3_ur_reg);
        s4_us2_next           = SQ_W'(s3_us_reg) * SQ_W'(s3_us_reg);
        s4_p_next             = P_W'(s3_ur_reg) * P_W'(size_b_reg);
        s4_q_next             = P_W'(s3_us_reg) * P_W'(size_a_reg);
    end

    // Stage 5: circle compare, and half-width partial products of the
    // ellipse squares.
    always_comb
    begin
        circ_sum              = C_W'(s4_ur2_reg) + C_W'(s4_us2_reg);
        circ_lim              = C_W'(aa_reg) << (2 * TRIG_FRAC_BITS);
        s5_flags_next         = s4_flags_reg;
        s5_flags_next.circ_ok = circ_sum <= circ_lim;
        p_hi                  = s4_p_reg[P_W-1:PL_W];
        p_lo                  = s4_p_reg[PL_W-1:0];
        q_hi                  = s4_q_reg[P_W-1:PL_W];
        q_lo                  = s4_q_reg[PL_W-1:0];
        s5_phh_next           = PHH_W'(p_hi) * PHH_W'(p_hi);
        s5_phl_next           = PHL_W'(p_hi) * PHL_W'(p_lo);
        s5_pll_next           = PLL_W'(p_lo) * PLL_W'(p_lo);
        s5_qhh_next           = PHH_W'(q_hi) * PHH_W'(q_hi);
        s5_qhl_next           = PHL_W'(q_hi) * PHL_W'(q_lo);
        s5_qll_next           = PLL_W'(q_lo) * PLL_W'(q_lo);
    end

    // Stage 6: assemble the two ellipse squares from their partial products.
    always_comb
    begin
        s6_p2_next = (PSQ_W'(s5_phh_reg) << (2 * PL_W))
                     + (PSQ_W'(s5_phl_reg) << (PL_W + 1))
                     + PSQ_W'(s5_pll_reg);
        s6_q2_next = (PSQ_W'(s5_qhh_reg) << (2 * PL_W))
                     + (PSQ_W'(s5_qhl_reg) << (PL_W + 1))
                     + PSQ_W'(s5_qll_reg);
    end

    // Stage 7: ellipse compare, shape select and blackout of blocked pixels.
    always_comb
    begin
        ell_sum = E_W'(s6_p2_reg) + E_W'(s6_q2_reg);
        ell_lim = E_W'(abab_reg) << (2 * TRIG_FRAC_BITS);
        ell_ok  = ell_sum <= ell_lim;
        case (shape_kind_reg)
            SHAPE_WIRE:    shape_hit = s6_flags_reg.wire_ok;
            SHAPE_CIRCLE:  shape_hit = s6_flags_reg.circ_ok;
            SHAPE_ELLIPSE: shape_hit = ell_ok;
            SHAPE_SQUARE:  shape_hit = s6_flags_reg.wire_ok && s6_flags_reg.sq_ok;
            default:       shape_hit = 1'b0;
        endcase
        s7_blocked_next = s6_pass_reg.mask && shape_hit;
        s7_pass_next    = s7_blocked_next ? '0 : s6_pass_reg;
    end

    // Stage registers; payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pass_reg <= s1_pass_next;
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
        end
        if (en2)
        begin
            s2_pass_reg <= s1_pass_reg;
            s2_cdx_reg  <= s2_cdx_next;
            s2_sdy_reg  <= s2_sdy_next;
            s2_cdy_reg  <= s2_cdy_next;
            s2_sdx_reg  <= s2_sdx_next;
        end
        if (en3)
        begin
            s3_pass_reg <= s2_pass_reg;
            s3_ur_reg   <= s3_ur_next;
            s3_us_reg   <= s3_us_next;
        end
        if (en4)
        begin
            s4_pass_reg  <= s3_pass_reg;
            s4_flags_reg <= s4_flags_next;
            s4_ur2_reg   <= s4_ur2_next;
            s4_us2_reg   <= s4_us2_next;
            s4_p_reg     <= s4_p_next;
            s4_q_reg     <= s4_q_next;
        end
        if (en5)
        begin
            s5_pass_reg  <= s4_pass_reg;
            s5_flags_reg <= s5_flags_next;
            s5_phh_reg   <= s5_phh_next;
            s5_phl_reg   <= s5_phl_next;
            s5_pll_reg   <= s5_pll_next;
            s5_qhh_reg   <= s5_qhh_next;
            s5_qhl_reg   <= s5_qhl_next;
            s5_qll_reg   <= s5_qll_next;
        end
        if (en6)
        begin
            s6_pass_reg  <= s5_pass_reg;
            s6_flags_reg <= s5_flags_reg;
            s6_p2_reg    <= s6_p2_next;
            s6_q2_reg    <= s6_q2_next;
        end
        if (en7)
        begin
            s7_pass_reg    <= s7_pass_next;
            s7_blocked_reg <= s7_blocked_next;
        end
    end

    // Output word
    assign out_valid   = s7_v_reg;
    assign red_out     = s7_pass_reg.red;
    assign green_out   = s7_pass_reg.green;
    assign blue_out    = s7_pass_reg.blue;
    assign mask_out    = s7_pass_reg.mask;
    assign was_blocked = s7_blocked_reg;

endmodule
`default_nettype wire
